// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int PRIO_W  = 8;
  localparam int CUST_W  = 16;
  localparam int ITEMS_W = 16;
  localparam int OCC_W   = 5;
  localparam int STS_W   = 2;

  localparam int IN_DATA_W  = PRIO_W + CUST_W + ITEMS_W;
  localparam int OUT_DATA_W = PRIO_W + CUST_W + ITEMS_W + OCC_W + 1 + STS_W;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic {
    STATE_IDLE,
    STATE_HOLD
  } state_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::STATE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::STATE_IDLE: begin
        if (take) state_next = spq_pkg::STATE_HOLD;
      end
      spq_pkg::STATE_HOLD: begin
        // a new word can replace the one leaving this cycle
        if (!take && out_ready) state_next = spq_pkg::STATE_IDLE;
      end
      default: state_next = spq_pkg::STATE_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      spq_pkg::STATE_IDLE: begin
        in_ready = 1'b1;
      end
      spq_pkg::STATE_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.exec = in_valid && in_ready;
  end

endmodule

// ===== sv/spq_dp.sv =====
module spq_dp #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spq_pkg::cmd_t                cmd,
  input  logic                         action,
  input  logic [spq_pkg::PRIO_W-1:0]   priority_req,
  input  logic [spq_pkg::CUST_W-1:0]   customer_id,
  input  logic [spq_pkg::ITEMS_W-1:0]  item_count,
  output logic                         removed_valid,
  output logic [spq_pkg::PRIO_W-1:0]   removed_priority,
  output logic [spq_pkg::CUST_W-1:0]   removed_customer,
  output logic [spq_pkg::ITEMS_W-1:0]  removed_items,
  output logic [spq_pkg::OCC_W-1:0]    occupancy,
  output logic                         is_empty,
  output logic [spq_pkg::STS_W-1:0]    status
);

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::CUST_W-1:0]  cust;
    logic [spq_pkg::ITEMS_W-1:0] items;
  } entry_t;

  entry_t              cells      [CAPACITY];
  entry_t              cells_next [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] prev_le;
  entry_t              below      [CAPACITY];
  entry_t              above      [CAPACITY];
  entry_t              new_entry;

  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;
  logic                full;
  logic                empty;
  logic                ins_ok;
  logic                rem_ok;
  logic [CntW+spq_pkg::OCC_W-1:0] occ_ext;

  assign new_entry = '{prio: priority_req, cust: customer_id, items: item_count};
  assign full      = (count == CntW'(CAPACITY));
  assign empty     = (count == '0);
  assign ins_ok    = cmd.exec && (action == spq_pkg::ACT_INSERT) && !full;
  assign rem_ok    = cmd.exec && (action == spq_pkg::ACT_REMOVE) && !empty;

  // Each cell compares itself with the new priority; the held cells that
  // sort before or equal to it form a prefix, the rest shift down one place.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    assign le[gi] = (CntW'(gi) < count) && (cells[gi].prio <= priority_req);

    if (gi == 0) begin : g_first
      assign prev_le[gi] = 1'b1;
      assign below[gi]   = new_entry;
    end else begin : g_rest
      assign prev_le[gi] = le[gi-1];
      assign below[gi]   = cells[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign above[gi] = cells[gi];
    end else begin : g_mid
      assign above[gi] = cells[gi+1];
    end

    always_comb begin
      cells_next[gi] = cells[gi];
      if (ins_ok) begin
        if (le[gi]) begin
          cells_next[gi] = cells[gi];
        end else if (prev_le[gi]) begin
          cells_next[gi] = new_entry;
        end else begin
          cells_next[gi] = below[gi];
        end
      end else if (rem_ok) begin
        cells_next[gi] = above[gi];
      end
    end

    always_ff @(posedge clk) begin
      cells[gi] <= cells_next[gi];
    end
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CntW'(1);
    end else if (rem_ok) begin
      count_next = count - CntW'(1);
    end
  end

  assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      removed_valid    <= rem_ok;
      removed_priority <= rem_ok ? cells[0].prio  : '0;
      removed_customer <= rem_ok ? cells[0].cust  : '0;
      removed_items    <= rem_ok ? cells[0].items : '0;
      occupancy        <= occ_ext[spq_pkg::OCC_W-1:0];
      is_empty         <= (count_next == '0);
      if (action == spq_pkg::ACT_INSERT) begin
        status <= full ? spq_pkg::STS_FULL : spq_pkg::STS_OK;
      end else begin
        status <= empty ? spq_pkg::STS_EMPTY : spq_pkg::STS_OK;
      end
    end
  end

endmodule

// ===== sv/stable_priority_queue.sv =====
// Sorted priority queue of up to CAPACITY customer entries. Each input word
// either inserts an entry (tuser 0) or removes the head (tuser 1), and each
// produces exactly one output word carrying the removed entry, the occupancy
// after the operation, an empty flag and a status code. Lowest priority value
// leaves first; equal priorities leave in arrival order. The entries sit in a
// row of register cells that all compare against the new priority at once,
// so an operation completes in the cycle it is accepted and the result is
// shown the next cycle from an output register. With the output taken every
// cycle the block accepts one word per clock; a stalled output holds the
// result and blocks input until it drains. Removal from an empty queue and
// insertion into a full queue change nothing and are reported in status.
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // priority_req[7:0], customer_id[23:8], item_count[39:24]
  input  logic [spq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action (0 insert, 1 remove)
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // removed_priority[7:0], removed_customer[23:8], removed_items[39:24],
  // occupancy[44:40], is_empty[45], status[47:46]
  output logic [spq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // removed_valid
  output logic                              m_axis_tuser
);

  spq_pkg::cmd_t                 cmd;
  logic [spq_pkg::PRIO_W-1:0]    removed_priority;
  logic [spq_pkg::CUST_W-1:0]    removed_customer;
  logic [spq_pkg::ITEMS_W-1:0]   removed_items;
  logic [spq_pkg::OCC_W-1:0]     occupancy;
  logic                          is_empty;
  logic [spq_pkg::STS_W-1:0]     status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .action           (s_axis_tuser),
    .priority_req     (s_axis_tdata[7:0]),
    .customer_id      (s_axis_tdata[23:8]),
    .item_count       (s_axis_tdata[39:24]),
    .removed_valid    (m_axis_tuser),
    .removed_priority (removed_priority),
    .removed_customer (removed_customer),
    .removed_items    (removed_items),
    .occupancy        (occupancy),
    .is_empty         (is_empty),
    .status           (status)
  );

  assign m_axis_tdata = {status, is_empty, occupancy,
                         removed_items, removed_customer, removed_priority};

  // held result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // every accepted word produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // failed removal leaves the queue empty and removes nothing
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == spq_pkg::STS_EMPTY) |-> (is_empty && !m_axis_tuser))
    else $error("empty status inconsistent");

  // a removal never reports a failure code
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (status == spq_pkg::STS_OK))
    else $error("removed entry with error status");

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
module stable_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = spq_pkg::CAPACITY_DEF;
  localparam int RANDOM_WORDS = 800;
  localparam int CALM_TAIL    = 120;   // last words run with no idling
  localparam int HOLD_AT      = 300;   // words accepted before the long output stall
  localparam int HOLD_LEN     = 200;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::CUST_W-1:0]  cust;
    logic [spq_pkg::ITEMS_W-1:0] items;
  } entry_t;

  typedef struct packed {
    logic   act;
    entry_t ent;
  } op_word_t;

  typedef struct packed {
    logic                        removed;
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::CUST_W-1:0]  cust;
    logic [spq_pkg::ITEMS_W-1:0] items;
    logic [spq_pkg::OCC_W-1:0]   occ;
    logic                        empty;
    logic [spq_pkg::STS_W-1:0]   status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // priority_req[7:0], customer_id[23:8], item_count[39:24]
  logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // action (0 insert, 1 remove)
  logic                           s_axis_tuser = spq_pkg::ACT_INSERT;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // removed_priority[7:0], removed_customer[23:8], removed_items[39:24],
  // occupancy[44:40], is_empty[45], status[47:46]
  logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // removed_valid
  logic                           m_axis_tuser;

  op_word_t pending_ops[$];
  outcome_t due_outcomes[$];

  // shadow copy of the sorted store
  entry_t held[CAPACITY];
  int     held_count;

  int errors      = 0;
  int accepted_in = 0;
  int cycles      = 0;
  int src_gap     = 0;
  int sink_gap    = 0;
  int hold_left   = 0;
  logic hold_done = 1'b0;
  logic quiet     = 1'b0;

  stable_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Applies one operation to the shadow store and queues the word it produces.
  task automatic apply_queue_op(input logic act, input entry_t ent);
    outcome_t o;
    int pos;
    int k;
    o = '0;
    if (act == spq_pkg::ACT_INSERT) begin
      if (held_count >= CAPACITY) begin
        o.status = spq_pkg::STS_FULL;
      end else begin
        pos = 0;
        // stable: new entry lands behind every entry of equal priority
        while (pos < held_count && held[pos].prio <= ent.prio) pos++;
        for (k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos] = ent;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        o.status = spq_pkg::STS_EMPTY;
      end else begin
        o.removed = 1'b1;
        o.prio    = held[0].prio;
        o.cust    = held[0].cust;
        o.items   = held[0].items;
        for (k = 1; k < held_count; k++) held[k-1] = held[k];
        held_count--;
      end
    end
    o.occ   = spq_pkg::OCC_W'(held_count);
    o.empty = (held_count == 0);
    due_outcomes.push_back(o);
  endtask

  task automatic queue_op(input logic act, input logic [spq_pkg::PRIO_W-1:0] prio,
                          input logic [spq_pkg::CUST_W-1:0] cust,
                          input logic [spq_pkg::ITEMS_W-1:0] items);
    op_word_t w;
    w.act       = act;
    w.ent.prio  = prio;
    w.ent.cust  = cust;
    w.ent.items = items;
    pending_ops.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    op_word_t w;
    entry_t acc;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      held_count = 0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.prio  = s_axis_tdata[7:0];
        acc.cust  = s_axis_tdata[23:8];
        acc.items = s_axis_tdata[39:24];
        apply_queue_op(s_axis_tuser, acc);
        accepted_in <= accepted_in + 1;
      end
      quiet <= (pending_ops.size() < CALM_TAIL);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          w = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= w.act;
          s_axis_tdata  <= {w.ent.items, w.ent.cust, w.ent.prio};
          if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 5);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output stall, once, so the block backs up and drops s_axis_tready
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_in == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_outcomes.size() == 0) begin
          flag_mismatch("unexpected word", m_axis_tdata[31:0], 0);
        end else begin
          want = due_outcomes.pop_front();
          if (m_axis_tuser !== want.removed)
            flag_mismatch("removed_valid", 32'(m_axis_tuser), 32'(want.removed));
          if (m_axis_tdata[7:0] !== want.prio)
            flag_mismatch("removed_priority", 32'(m_axis_tdata[7:0]), 32'(want.prio));
          if (m_axis_tdata[23:8] !== want.cust)
            flag_mismatch("removed_customer", 32'(m_axis_tdata[23:8]), 32'(want.cust));
          if (m_axis_tdata[39:24] !== want.items)
            flag_mismatch("removed_items", 32'(m_axis_tdata[39:24]), 32'(want.items));
          if (m_axis_tdata[44:40] !== want.occ)
            flag_mismatch("occupancy", 32'(m_axis_tdata[44:40]), 32'(want.occ));
          if (m_axis_tdata[45] !== want.empty)
            flag_mismatch("is_empty", 32'(m_axis_tdata[45]), 32'(want.empty));
          if (m_axis_tdata[47:46] !== want.status)
            flag_mismatch("status", 32'(m_axis_tdata[47:46]), 32'(want.status));
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int i;
    int mode;
    int pick;
    logic act;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::PRIO_W-1:0] band;

    // directed: empty pop, field extremes, ties, fill to full, full insert, removals
    queue_op(spq_pkg::ACT_REMOVE, 8'h00, 16'h0000, 16'h0000);
    queue_op(spq_pkg::ACT_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_op(spq_pkg::ACT_INSERT, 8'h00, 16'h0000, 16'h0000);
    for (i = 0; i < CAPACITY - 2; i++) begin
      case (i % 4)
        0, 2: prio = 8'h40;
        1: prio = 8'h10;
        default: prio = 8'hFF;
      endcase
      queue_op(spq_pkg::ACT_INSERT, prio, 16'h1000 + 16'(i), ~(16'h1000 + 16'(i)));
    end
    // dropped, queue full
    queue_op(spq_pkg::ACT_INSERT, 8'h00, 16'hDEAD, 16'hBEEF);
    for (i = 0; i < 4; i++) queue_op(spq_pkg::ACT_REMOVE, 8'hA5, 16'h5A5A, 16'hA5A5);

    // random: runs that fill, drain, or mix, with clustered priorities for ties
    mode = 2;
    band = 8'h00;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) begin
        mode = $urandom_range(0, 2);
        band = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      case (mode)
        0: act = (pick < 25) ? spq_pkg::ACT_REMOVE : spq_pkg::ACT_INSERT;
        1: act = (pick < 75) ? spq_pkg::ACT_REMOVE : spq_pkg::ACT_INSERT;
        default: act = (pick < 50) ? spq_pkg::ACT_REMOVE : spq_pkg::ACT_INSERT;
      endcase
      if ($urandom_range(0, 3) == 0) prio = 8'($urandom_range(0, 255));
      else prio = band + 8'($urandom_range(0, 3));
      queue_op(act, prio, 16'($urandom), 16'($urandom));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (due_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
